// ===== hdl/gnds_pkg.sv =====
// ----------------------------------------------------------------------------
// Grid diffusion step package
// Shared sizes, register indexes and the operand item passed from the
// front to the arithmetic back end.
// ----------------------------------------------------------------------------
package gnds_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ADDR_W    = COL_W + 1;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int ROW_W     = $clog2(MAX_HEIGHT + 1);
  localparam int CFG_W     = 11;
  localparam int WID_W     = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
  localparam int CFG_IDX_W = 8;
  localparam int DATA_W    = 32;
  localparam int SUM_W     = 35;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0]     GRID_RESET      = CFG_W'(1024);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W-31){1'b1}}, {31{1'b0}}};

  // one channel of a stencil: absent neighbors already replaced by the center
  typedef struct packed {
    logic signed [DATA_W-1:0] ctr;
    logic signed [DATA_W-1:0] up;
    logic signed [DATA_W-1:0] down;
    logic signed [DATA_W-1:0] left;
    logic signed [DATA_W-1:0] right;
  } gnds_chan_t;

  typedef struct packed {
    gnds_chan_t pol;
    gnds_chan_t land;
    logic       frame_end;
  } gnds_ops_t;

endpackage

// ===== hdl/gnds_front.sv =====
// ----------------------------------------------------------------------------
// Grid diffusion step front end
// Configuration registers, raster counters, two-bank line stores and the
// center/left window. Classifies each transfer and forms stencil operands.
// ----------------------------------------------------------------------------
module gnds_front import gnds_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [DATA_W-1:0]    pollution,
  input  logic signed [DATA_W-1:0]    land_value,
  input  logic                        drain,
  input  logic [QCNT_W-1:0]           q_count,
  output logic                        push_valid,
  output gnds_ops_t                   push_ops
);

  logic [CFG_W-1:0]  grid_width;
  logic [CFG_W-1:0]  grid_height;
  logic [WID_W-1:0]  w_eff;
  logic [COL_W-1:0]  last_col;
  logic [ROW_W-1:0]  h_eff;

  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;

  logic              in_fire;
  logic              in_phase;
  logic              col_last;
  logic              wr_en;
  logic              emit;
  logic              upd;
  logic [ADDR_W-1:0] addr_a;
  logic [ADDR_W-1:0] addr_b;

  logic signed [DATA_W-1:0] pol_mem  [MEM_DEPTH];
  logic signed [DATA_W-1:0] land_mem [MEM_DEPTH];
  logic signed [DATA_W-1:0] rda_p, rda_l, rdb_p, rdb_l;

  logic                     f1_emit, f1_upd;
  logic                     f1_up, f1_down, f1_left, f1_right, f1_end;
  logic signed [DATA_W-1:0] f1_dp, f1_dl;
  logic signed [DATA_W-1:0] nxt_p, nxt_l, cur_p, cur_l;

  always_comb begin
    if (grid_width < CFG_W'(2)) begin
      w_eff = WID_W'(2);
    end else if (WID_W'(grid_width) > WID_W'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = WID_W'(grid_width);
    end
    if (grid_height < CFG_W'(2)) begin
      h_eff = ROW_W'(2);
    end else if (ROW_W'(grid_height) > ROW_W'(MAX_HEIGHT)) begin
      h_eff = ROW_W'(MAX_HEIGHT);
    end else begin
      h_eff = ROW_W'(grid_height);
    end
  end

  assign last_col = COL_W'(w_eff - WID_W'(1));

  assign in_ready = ({1'b0, q_count} + (QCNT_W+1)'(f1_emit)) < (QCNT_W+1)'(QDEPTH);
  assign in_fire  = in_valid & in_ready;
  assign in_phase = row < h_eff;
  assign col_last = col == last_col;
  assign wr_en    = in_phase & ~drain;
  assign emit     = in_phase ? (~drain & (row != '0)) : drain;
  assign upd      = emit | (wr_en & col_last);

  // port A: two rows up (same bank as the write), port B: right neighbor,
  // or column 0 of the row just finished at the end of a row
  assign addr_a = {row[0], col};
  assign addr_b = col_last ? {row[0], COL_W'(0)} : {~row[0], col + COL_W'(1)};

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_RESET;
      grid_height <= GRID_RESET;
      row         <= '0;
      col         <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GRID_WIDTH: begin
          grid_width <= cfg_data;
          row        <= '0;
          col        <= '0;
        end
        REG_GRID_HEIGHT: begin
          grid_height <= cfg_data;
          row         <= '0;
          col         <= '0;
        end
        default: begin
        end
      endcase
    end else if (in_fire && (wr_en || emit)) begin
      if (col_last) begin
        col <= '0;
        row <= in_phase ? row + ROW_W'(1) : '0;
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rda_p <= pol_mem[addr_a];
      rda_l <= land_mem[addr_a];
      rdb_p <= pol_mem[addr_b];
      rdb_l <= land_mem[addr_b];
      if (wr_en) begin
        pol_mem[addr_a]  <= pollution;
        land_mem[addr_a] <= land_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_emit <= 1'b0;
      f1_upd  <= 1'b0;
    end else begin
      f1_emit <= in_fire & emit;
      f1_upd  <= in_fire & upd;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      f1_up    <= row > ROW_W'(1);
      f1_down  <= in_phase;
      f1_left  <= col != '0;
      f1_right <= ~col_last;
      f1_end   <= ~in_phase & col_last;
      f1_dp    <= pollution;
      f1_dl    <= land_value;
    end
  end

  always_ff @(posedge clk) begin
    if (f1_upd) begin
      nxt_p <= rdb_p;
      nxt_l <= rdb_l;
    end
    if (f1_emit) begin
      cur_p <= nxt_p;
      cur_l <= nxt_l;
    end
  end

  always_comb begin
    push_valid          = f1_emit;
    push_ops.pol.ctr    = nxt_p;
    push_ops.pol.up     = f1_up    ? rda_p : nxt_p;
    push_ops.pol.down   = f1_down  ? f1_dp : nxt_p;
    push_ops.pol.left   = f1_left  ? cur_p : nxt_p;
    push_ops.pol.right  = f1_right ? rdb_p : nxt_p;
    push_ops.land.ctr   = nxt_l;
    push_ops.land.up    = f1_up    ? rda_l : nxt_l;
    push_ops.land.down  = f1_down  ? f1_dl : nxt_l;
    push_ops.land.left  = f1_left  ? cur_l : nxt_l;
    push_ops.land.right = f1_right ? rdb_l : nxt_l;
    push_ops.frame_end  = f1_end;
  end

endmodule

// ===== hdl/gnds_queue.sv =====
// ----------------------------------------------------------------------------
// Grid diffusion step operand queue
// Small FIFO between the front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module gnds_queue import gnds_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  input  gnds_ops_t         push_ops,
  input  logic              q_take,
  output logic              q_valid,
  output gnds_ops_t         q_ops,
  output logic [QCNT_W-1:0] q_count
);

  gnds_ops_t          slots [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;

  assign q_valid = q_count != '0;
  assign q_ops   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push_valid) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (q_take) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      q_count <= q_count + QCNT_W'(push_valid) - QCNT_W'(q_take);
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      slots[wr_ptr] <= push_ops;
    end
  end

endmodule

// ===== hdl/gnds_back.sv =====
// ----------------------------------------------------------------------------
// Grid diffusion step back end
// Four-stage arithmetic pipeline: differences, quarter toward zero,
// partial sums, final sum with saturation into the output register.
// ----------------------------------------------------------------------------
module gnds_back import gnds_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  input  gnds_ops_t                q_ops,
  output logic                     q_take,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] new_pollution,
  output logic signed [DATA_W-1:0] new_land_value,
  output logic                     frame_end
);

  typedef struct packed {
    logic signed [DATA_W-1:0] ctr;
    logic signed [DATA_W:0]   du;
    logic signed [DATA_W:0]   dd;
    logic signed [DATA_W:0]   dl;
    logic signed [DATA_W:0]   dr;
  } dif_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] ctr;
    logic signed [DATA_W-2:0] qu;
    logic signed [DATA_W-2:0] qd;
    logic signed [DATA_W-2:0] ql;
    logic signed [DATA_W-2:0] qr;
  } qtr_t;

  typedef struct packed {
    logic signed [DATA_W+1:0] a0;
    logic signed [DATA_W-1:0] a1;
    logic signed [DATA_W-2:0] a2;
  } part_t;

  function automatic dif_t f_diff(gnds_chan_t c);
    dif_t r;
    r.ctr = c.ctr;
    r.du  = (DATA_W+1)'(c.up)    - (DATA_W+1)'(c.ctr);
    r.dd  = (DATA_W+1)'(c.down)  - (DATA_W+1)'(c.ctr);
    r.dl  = (DATA_W+1)'(c.left)  - (DATA_W+1)'(c.ctr);
    r.dr  = (DATA_W+1)'(c.right) - (DATA_W+1)'(c.ctr);
    return r;
  endfunction

  // divide by 4, truncating toward zero
  function automatic logic signed [DATA_W-2:0] f_quarter(logic signed [DATA_W:0] d);
    logic signed [DATA_W:0] b;
    b = d + (d[DATA_W] ? (DATA_W+1)'(3) : (DATA_W+1)'(0));
    return b[DATA_W:2];
  endfunction

  function automatic qtr_t f_qtr(dif_t d);
    qtr_t r;
    r.ctr = d.ctr;
    r.qu  = f_quarter(d.du);
    r.qd  = f_quarter(d.dd);
    r.ql  = f_quarter(d.dl);
    r.qr  = f_quarter(d.dr);
    return r;
  endfunction

  function automatic part_t f_part(qtr_t q);
    part_t r;
    r.a0 = (DATA_W+2)'(q.ctr) + (DATA_W+2)'(q.qu);
    r.a1 = DATA_W'(q.qd) + DATA_W'(q.ql);
    r.a2 = q.qr;
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] f_sum_sat(part_t p);
    logic signed [SUM_W-1:0] s;
    s = SUM_W'(p.a0) + SUM_W'(p.a1) + SUM_W'(p.a2);
    if (s > SAT_HI) begin
      return SAT_HI[DATA_W-1:0];
    end else if (s < SAT_LO) begin
      return SAT_LO[DATA_W-1:0];
    end
    return s[DATA_W-1:0];
  endfunction

  logic  v1, v2, v3, v4;
  logic  ld1, ld2, ld3, ld4;
  dif_t  s1_p, s1_l;
  qtr_t  s2_p, s2_l;
  part_t s3_p, s3_l;
  logic  s1_end, s2_end, s3_end;

  assign ld4       = ~v4 | out_ready;
  assign ld3       = ~v3 | ld4;
  assign ld2       = ~v2 | ld3;
  assign ld1       = ~v1 | ld2;
  assign q_take    = q_valid & ld1;
  assign out_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (ld1) begin
        v1 <= q_valid;
      end
      if (ld2) begin
        v2 <= v1;
      end
      if (ld3) begin
        v3 <= v2;
      end
      if (ld4) begin
        v4 <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      s1_p   <= f_diff(q_ops.pol);
      s1_l   <= f_diff(q_ops.land);
      s1_end <= q_ops.frame_end;
    end
    if (ld2 && v1) begin
      s2_p   <= f_qtr(s1_p);
      s2_l   <= f_qtr(s1_l);
      s2_end <= s1_end;
    end
    if (ld3 && v2) begin
      s3_p   <= f_part(s2_p);
      s3_l   <= f_part(s2_l);
      s3_end <= s2_end;
    end
    if (ld4 && v3) begin
      new_pollution  <= f_sum_sat(s3_p);
      new_land_value <= f_sum_sat(s3_l);
      frame_end      <= s3_end;
    end
  end

endmodule

// ===== hdl/grid_neighbor_diffusion_step_unit.sv =====
// ----------------------------------------------------------------------------
// Grid neighbor diffusion step unit
// Takes grid cells in raster order and returns each cell of row r, updated by
// a five-point diffusion stencil, while row r+1 streams in; drain transfers
// push out the last row, and the final cell carries frame_end. The block
// sustains one transfer per clock: each cell needs two line-store reads
// (the row above and the right neighbor) on the two read ports of each
// store, and the center and left values come from a two-entry window. Each
// result is registered in the front end, queued, and then computed by the
// arithmetic back-end pipeline. in_ready drops only when the four-entry
// operand queue backs up behind a stalled output. Configuration writes
// restart the frame; no clearing pass runs after reset.
// ----------------------------------------------------------------------------
module grid_neighbor_diffusion_step_unit import gnds_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] pollution,
  input  logic signed [DATA_W-1:0] land_value,
  input  logic                     drain,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] new_pollution,
  output logic signed [DATA_W-1:0] new_land_value,
  output logic                     frame_end
);

  logic              push_valid;
  gnds_ops_t         push_ops;
  logic              q_valid;
  gnds_ops_t         q_ops;
  logic              q_take;
  logic [QCNT_W-1:0] q_count;

  assign cfg_ready = 1'b1;

  gnds_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pollution  (pollution),
    .land_value (land_value),
    .drain      (drain),
    .q_count    (q_count),
    .push_valid (push_valid),
    .push_ops   (push_ops)
  );

  gnds_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ops   (push_ops),
    .q_take     (q_take),
    .q_valid    (q_valid),
    .q_ops      (q_ops),
    .q_count    (q_count)
  );

  gnds_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_ops          (q_ops),
    .q_take         (q_take),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .new_pollution  (new_pollution),
    .new_land_value (new_land_value),
    .frame_end      (frame_end)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> (q_count != QCNT_W'(QDEPTH)))
    else $error("operand queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_take |-> (q_count != '0))
    else $error("operand queue underflow");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    (q_count == '0) |-> in_ready)
    else $error("input stalled with empty queue");

endmodule

// ===== tb/grid_neighbor_diffusion_step_unit_checker.sv =====
// ----------------------------------------------------------------------------
// Grid diffusion step checker
// Watches the register, cell and update channels of the diffusion unit.
// Keeps its own line stores and raster counters, predicts each updated cell
// when its transfer is seen, and compares every update transfer in order.
// ----------------------------------------------------------------------------
module grid_neighbor_diffusion_step_unit_checker import gnds_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic signed [DATA_W-1:0] pollution,
  input  logic signed [DATA_W-1:0] land_value,
  input  logic                     drain,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [DATA_W-1:0] new_pollution,
  input  logic signed [DATA_W-1:0] new_land_value,
  input  logic                     frame_end,
  output int                       fail_count,
  output int                       pending
);

  localparam longint SPREAD_DIV = 4;

  typedef struct {
    logic signed [DATA_W-1:0] new_pol;
    logic signed [DATA_W-1:0] new_land;
    logic                     is_last;
  } cell_update_t;

  cell_update_t             expected_cells[$];
  logic [CFG_W-1:0]         grid_width;
  logic [CFG_W-1:0]         grid_height;
  logic signed [DATA_W-1:0] pol_line [MEM_DEPTH];
  logic signed [DATA_W-1:0] land_line [MEM_DEPTH];
  int unsigned              col_in, row_in, col_out, row_out;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic int unsigned dim_of(input logic [CFG_W-1:0] v, input int unsigned cap);
    int unsigned n;
    n = 32'(v);
    if (n < 2) return 2;
    if (n > cap) return cap;
    return n;
  endfunction

  function automatic int unsigned line_slot(input int unsigned row, input int unsigned col);
    return (row % 2) * MAX_WIDTH + col;
  endfunction

  function automatic longint spread(input logic signed [DATA_W-1:0] nb, input longint ctr);
    longint n;
    n = nb;
    return (n - ctr) / SPREAD_DIV;
  endfunction

  function automatic logic signed [DATA_W-1:0] clip(input longint v);
    if (v > 64'sd2147483647) return {1'b0, {(DATA_W-1){1'b1}}};
    if (v < -64'sd2147483648) return {1'b1, {(DATA_W-1){1'b0}}};
    return DATA_W'(v);
  endfunction

  task automatic clear_position();
    col_in = 0;
    row_in = 0;
    col_out = 0;
    row_out = 0;
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    case (idx)
      REG_GRID_WIDTH: begin
        grid_width = val;
        clear_position();
      end
      REG_GRID_HEIGHT: begin
        grid_height = val;
        clear_position();
      end
      default: ;
    endcase
  endtask

  // diffuse the cell at the output position; the cell below, when present, is the input
  task automatic push_update(input bit has_below, input logic signed [DATA_W-1:0] below_p,
                             input logic signed [DATA_W-1:0] below_l,
                             input int unsigned w, input int unsigned h);
    int unsigned  r, c;
    longint       cp, cl, sp, sl;
    cell_update_t upd;
    r = row_out;
    c = col_out;
    cp = pol_line[line_slot(r, c)];
    cl = land_line[line_slot(r, c)];
    sp = cp;
    sl = cl;
    if (has_below) begin
      sp += spread(below_p, cp);
      sl += spread(below_l, cl);
    end
    if (r > 0) begin
      sp += spread(pol_line[line_slot(r - 1, c)], cp);
      sl += spread(land_line[line_slot(r - 1, c)], cl);
    end
    if (c + 1 < w) begin
      sp += spread(pol_line[line_slot(r, c + 1)], cp);
      sl += spread(land_line[line_slot(r, c + 1)], cl);
    end
    if (c > 0) begin
      sp += spread(pol_line[line_slot(r, c - 1)], cp);
      sl += spread(land_line[line_slot(r, c - 1)], cl);
    end
    upd.new_pol = clip(sp);
    upd.new_land = clip(sl);
    upd.is_last = (r + 1 == h) && (c + 1 == w);
    expected_cells.push_back(upd);
    col_out++;
    if (col_out >= w) begin
      col_out = 0;
      row_out++;
    end
  endtask

  task automatic take_cell(input logic signed [DATA_W-1:0] p, input logic signed [DATA_W-1:0] l,
                           input logic d);
    int unsigned w, h;
    w = dim_of(grid_width, MAX_WIDTH);
    h = dim_of(grid_height, MAX_HEIGHT);
    if (row_in < h) begin
      if (!d) begin
        if (row_in > 0) push_update(1'b1, p, l, w, h);
        pol_line[line_slot(row_in, col_in)] = p;
        land_line[line_slot(row_in, col_in)] = l;
        col_in++;
        if (col_in >= w) begin
          col_in = 0;
          row_in++;
        end
      end
    end else if (d) begin
      push_update(1'b0, '0, '0, w, h);
      if (row_out >= h) clear_position();
    end
  endtask

  task automatic check_update();
    cell_update_t exp_upd;
    if (expected_cells.size() == 0) begin
      if (fail_count < 10)
        $display("unexpected update: pol %0d land %0d end %0b",
                 new_pollution, new_land_value, frame_end);
      fail_count++;
    end else begin
      exp_upd = expected_cells.pop_front();
      if (new_pollution !== exp_upd.new_pol || new_land_value !== exp_upd.new_land ||
          frame_end !== exp_upd.is_last) begin
        if (fail_count < 10)
          $display("update mismatch: expected pol %0d land %0d end %0b, got pol %0d land %0d end %0b",
                   exp_upd.new_pol, exp_upd.new_land, exp_upd.is_last,
                   new_pollution, new_land_value, frame_end);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      grid_width = GRID_RESET;
      grid_height = GRID_RESET;
      clear_position();
      expected_cells.delete();
    end else begin
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (in_valid && in_ready) take_cell(pollution, land_value, drain);
      if (out_valid && out_ready) check_update();
    end
    pending = expected_cells.size();
  end

endmodule

// ===== tb/grid_neighbor_diffusion_step_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Grid diffusion step testbench
// Streams grid frames of many sizes through the diffusion unit: a short
// directed run over value extremes, stray drains and cells, register writes
// and frame restarts, the largest row and column counts, then random frames
// under phases of sender gaps and receiver stalls. A checker beside the unit
// predicts and compares every update.
// ----------------------------------------------------------------------------
module grid_neighbor_diffusion_step_unit_tb;
  import gnds_pkg::*;

  localparam logic [CFG_IDX_W-1:0]     REG_SPARE   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0]     REG_FAR     = '1;
  localparam logic signed [DATA_W-1:0] WORD_MAX    = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] WORD_MIN    = {1'b1, {(DATA_W-1){1'b0}}};
  localparam int                       STALL_LIMIT = 5000;
  localparam int unsigned              PHASE_ITEMS = 40;

  logic                     clk;
  logic                     rst;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_W-1:0]         cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [DATA_W-1:0] pollution;
  logic signed [DATA_W-1:0] land_value;
  logic                     drain;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] new_pollution;
  logic signed [DATA_W-1:0] new_land_value;
  logic                     frame_end;
  int                       fail_count;
  int                       pending;

  int          in_idle_pct = 0;
  int          out_stall_pct = 0;
  int          stall_cycles = 0;
  int unsigned sent_items = 0;
  int unsigned cur_w, cur_h;

  grid_neighbor_diffusion_step_unit u_top (.*);

  grid_neighbor_diffusion_step_unit_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("grid_neighbor_diffusion_step_unit_tb NOT OK");
      $finish;
    end
  end

  function automatic int unsigned dim_of(input logic [CFG_W-1:0] v, input int unsigned cap);
    int unsigned n;
    n = 32'(v);
    if (n < 2) return 2;
    if (n > cap) return cap;
    return n;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return '0;
      3:       return '1;
      4, 5:    return DATA_W'(int'($urandom_range(400)) - 200);
      default: return $urandom;
    endcase
  endfunction

  // all tasks start and end at a falling edge
  task automatic send_item(input logic signed [DATA_W-1:0] p, input logic signed [DATA_W-1:0] l,
                           input logic d);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pollution <= p;
    land_value <= l;
    drain <= d;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic settle();
    hold_until_drained();
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_grid(input logic [CFG_W-1:0] wv, input logic [CFG_W-1:0] hv);
    settle();
    write_reg(REG_GRID_WIDTH, wv);
    write_reg(REG_GRID_HEIGHT, hv);
    cur_w = dim_of(wv, MAX_WIDTH);
    cur_h = dim_of(hv, MAX_HEIGHT);
  endtask

  // one frame of cells then one drain per column; stop_at cuts it short
  task automatic run_frame(input int unsigned w, input int unsigned h, input bit noisy,
                           input int unsigned stop_at);
    for (int unsigned k = 0; k < w * h + w; k++) begin
      if (stop_at != 0 && k == stop_at) return;
      if (noisy && $urandom_range(49) == 0)
        send_item(pick_value(), pick_value(), k < w * h);
      if ($urandom_range(299) == 0) hold_until_drained();
      send_item(pick_value(), pick_value(), k >= w * h);
      sent_items++;
    end
  endtask

  initial begin
    logic [CFG_W-1:0] wv, hv;
    int unsigned      budget;
    bit               restart;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    pollution = '0;
    land_value = '0;
    drain = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_grid(CFG_W'(0), CFG_W'(1));
    write_reg(REG_SPARE, '1);
    write_reg(REG_FAR, '0);
    send_item(WORD_MAX, WORD_MIN, 1'b0);
    send_item(WORD_MIN, WORD_MAX, 1'b0);
    send_item('0, '0, 1'b1);
    send_item('0, '1, 1'b0);
    send_item(WORD_MAX, WORD_MAX, 1'b0);
    send_item('1, '1, 1'b0);
    hold_until_drained();
    send_item('0, '0, 1'b1);
    send_item('0, '0, 1'b1);
    // next frame follows the last drain directly
    send_item(WORD_MIN, WORD_MIN, 1'b0);
    send_item(WORD_MAX, WORD_MAX, 1'b0);
    send_item(WORD_MAX, WORD_MIN, 1'b0);
    send_item(WORD_MIN, WORD_MAX, 1'b0);
    send_item('1, '0, 1'b1);
    send_item('0, '1, 1'b1);
    set_grid(CFG_W'(2), CFG_W'(3));
    send_item(WORD_MAX, '0, 1'b0);
    send_item('0, WORD_MIN, 1'b0);
    send_item(WORD_MIN, WORD_MAX, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 86; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 86; end
        default: begin in_idle_pct = 30; out_stall_pct = 30; end
      endcase
      if (ph == 0) begin
        // widest row: past the row wrap and into the first updates
        set_grid(CFG_W'(2047), CFG_W'(2));
        run_frame(cur_w, cur_h, 1'b0, cur_w + 8);
        set_grid(CFG_W'(1), CFG_W'(1024));
        run_frame(cur_w, cur_h, 1'b0, 24);
        set_grid(CFG_W'(3), CFG_W'(2047));
        run_frame(cur_w, cur_h, 1'b0, 24);
      end
      budget = sent_items + PHASE_ITEMS;
      restart = 1'b1;
      while (sent_items < budget) begin
        if (restart || $urandom_range(2) == 0) begin
          case ($urandom_range(9))
            0:       wv = CFG_W'($urandom_range(1));
            1:       wv = CFG_W'($urandom_range(24, 9));
            default: wv = CFG_W'($urandom_range(6, 2));
          endcase
          case ($urandom_range(9))
            0:       hv = CFG_W'($urandom_range(1));
            1:       hv = CFG_W'($urandom_range(12, 6));
            default: hv = CFG_W'($urandom_range(5, 2));
          endcase
          set_grid(wv, hv);
          if ($urandom_range(3) == 0)
            write_reg($urandom_range(1) ? REG_FAR : CFG_IDX_W'($urandom_range(254, 2)),
                      CFG_W'($urandom));
        end
        restart = ($urandom_range(7) == 0);
        run_frame(cur_w, cur_h, ($urandom_range(1) == 1),
                  restart ? $urandom_range(1, cur_w * cur_h + cur_w - 1) : 0);
      end
    end

    settle();
    if (fail_count == 0 && pending == 0)
      $display("grid_neighbor_diffusion_step_unit_tb OK");
    else
      $display("grid_neighbor_diffusion_step_unit_tb NOT OK");
    $finish;
  end

endmodule
